// ===== rtl/lhpm_pkg.sv =====
// package: widths, bucket tables and helpers for the latency histogram monitor
`default_nettype none
package lhpm_pkg;

    localparam int CB      = 32;          // counter and bucket width
    localparam int NB      = 10;          // number of latency buckets
    localparam int NBW     = $clog2(NB);
    localparam int NCNT    = 6;
    localparam int TOT_W   = CB + 4;      // sum of all buckets
    localparam int SC_W    = CB + 11;     // percent-scaled counts
    localparam int DEN_W   = CB + 7;      // 100 * bucket count
    localparam int RNG_W   = 15;
    localparam int PROD_W  = DEN_W + RNG_W;
    localparam int LAT_W   = 15;
    localparam int BYTE_W  = 48;
    localparam int LAST_SPAN = 16000;

    // request counter slots
    localparam int C_TOT = 0;
    localparam int C_V1  = 1;
    localparam int C_V2  = 2;
    localparam int C_ERR = 3;
    localparam int C_EV1 = 4;
    localparam int C_EV2 = 5;

    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_FLUSH  = 1'b1;

    typedef logic [CB-1:0]    cnt_t;
    typedef logic [LAT_W-1:0] lat_t;

    // lower bound of a bucket
    function automatic lat_t bucket_low(input logic [NBW-1:0] idx);
        case (idx)
            4'd0:    return 15'd0;
            4'd1:    return 15'd64;
            4'd2:    return 15'd128;
            4'd3:    return 15'd256;
            4'd4:    return 15'd512;
            4'd5:    return 15'd1000;
            4'd6:    return 15'd2000;
            4'd7:    return 15'd4000;
            4'd8:    return 15'd8000;
            default: return 15'd16000;
        endcase
    endfunction

    // width of a bucket, last one spans a fixed range
    function automatic lat_t bucket_range(input logic [NBW-1:0] idx);
        if (idx == NBW'(NB - 1))
            return LAT_W'(LAST_SPAN);
        return bucket_low(idx + NBW'(1)) - bucket_low(idx);
    endfunction

    // bucket holding a latency
    function automatic logic [NBW-1:0] bucket_of(input logic [31:0] lat);
        logic [NBW-1:0] b;
        b = NBW'(NB - 1);
        for (int i = NB - 2; i >= 0; i--)
        begin
            if (lat < 32'(bucket_low(NBW'(i + 1))))
                b = NBW'(i);
        end
        return b;
    endfunction

    function automatic cnt_t sat_inc(input cnt_t v);
        return (&v) ? v : v + cnt_t'(1);
    endfunction

    function automatic logic [6:0] pct_target(input logic [1:0] ti);
        case (ti)
            2'd0:    return 7'd50;
            2'd1:    return 7'd90;
            default: return 7'd99;
        endcase
    endfunction

endpackage
`default_nettype wire

// ===== rtl/lhpm_item_if.sv =====
// interface: input word channel of the monitor
`default_nettype none
interface lhpm_item_if;
    logic        valid;
    logic        ready;
    logic        operation;
    logic [31:0] req_latency;
    logic [9:0]  resp_status;
    logic [31:0] byte_count;
    logic        is_second_protocol;

    modport source (output valid, operation, req_latency, resp_status, byte_count,
                    is_second_protocol, input ready);
    modport sink   (input valid, operation, req_latency, resp_status, byte_count,
                    is_second_protocol, output ready);
endinterface
`default_nettype wire

// ===== rtl/lhpm_result_if.sv =====
// interface: result word channel of the monitor
`default_nettype none
interface lhpm_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] requests_total;
    logic [31:0] requests_v1;
    logic [31:0] requests_v2;
    logic [31:0] errors_total;
    logic [31:0] errors_v1;
    logic [31:0] errors_v2;
    logic [47:0] bytes_total;
    logic [14:0] median_latency;
    logic [14:0] p90_latency;
    logic [14:0] p99_latency;

    modport source (output valid, requests_total, requests_v1, requests_v2,
                    errors_total, errors_v1, errors_v2, bytes_total,
                    median_latency, p90_latency, p99_latency, input ready);
    modport sink   (input valid, requests_total, requests_v1, requests_v2,
                    errors_total, errors_v1, errors_v2, bytes_total,
                    median_latency, p90_latency, p99_latency, output ready);
endinterface
`default_nettype wire

// ===== rtl/lhpm_ram.sv =====
// generic single-write, single-read ram with registered read
`default_nettype none
module lhpm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/latency_histogram_percentile_monitor_core.sv =====
// top level: latency histogram monitor with counters and percentile report
//
//   channel   direction  words
//   item      in         record (operation 0) or flush (operation 1)
//   result    out        counters and p50/p90/p99, one per flush
//
// a record reads its bucket from ram, then increments it and writes it back.
// a flush sums the histogram bucket by bucket (read, then accumulate), walks the buckets
// (read, then check) plus one target check per non-empty bucket, runs per percentile a
// check, a multiply and a 15-step divider, then loads the result and clears state.
// reset clears counters and bucket valid bits at once, no clearing pass.
// a flush waits at its end while the previous result is still not taken.
`default_nettype none
module latency_histogram_percentile_monitor_core (
    input  wire logic    clk,
    input  wire logic    rst_n,
    lhpm_item_if.sink    item,
    lhpm_result_if.source result
);
    import lhpm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_REC, S_SUM_RD, S_SUM_ACC, S_WALK_RD, S_WALK_CHK,
        S_TGT, S_MUL, S_DIV, S_OUT
    } state_t;

    state_t              state_reg;
    logic [NBW-1:0]      addr_reg;
    logic [NBW-1:0]      raddr_reg;
    logic [1:0]          ti_reg;
    logic [TOT_W-1:0]    total_reg;
    logic [TOT_W-1:0]    cum_reg;
    logic [TOT_W-1:0]    prev_reg;
    cnt_t                cnt_reg;
    logic [DEN_W-1:0]    num_reg;
    logic [DEN_W-1:0]    den_reg;
    logic [DEN_W-1:0]    rem_reg;
    logic [RNG_W-1:0]    low_reg;
    logic [RNG_W-1:0]    q_reg;
    logic [3:0]          step_reg;
    lat_t                pct_reg [3];
    cnt_t                ctr_reg [NCNT];
    logic [BYTE_W-1:0]   bytes_reg;
    logic [NB-1:0]       valid_reg;
    logic                out_valid_reg;

    logic [NBW-1:0]      raddr;
    cnt_t                rdata;
    cnt_t                rd_val;
    logic                ram_we;
    logic                acc;
    logic                is_err;
    logic [BYTE_W:0]     byte_sum;
    logic [SC_W-1:0]     want;
    logic [SC_W-1:0]     cum100;
    logic [SC_W-1:0]     prev100;
    logic [TOT_W-1:0]    total_sum;
    logic [DEN_W:0]      div_t;
    logic                div_ge;
    logic [RNG_W-1:0]    q_next;
    logic [PROD_W-1:0]   prod;
    logic                out_free;

    // bucket store
    lhpm_ram #(.WIDTH(CB), .DEPTH(NB)) u_bucket_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (raddr_reg),
        .wdata (sat_inc(rd_val)),
        .raddr (raddr),
        .rdata (rdata)
    );

    // handshake and read address
    assign item.ready = (state_reg == S_IDLE);
    assign acc        = item.valid && item.ready;
    assign raddr      = (state_reg == S_IDLE) ? bucket_of(item.req_latency) : addr_reg;
    assign rd_val     = valid_reg[raddr_reg] ? rdata : '0;
    assign ram_we     = (state_reg == S_REC);
    assign out_free   = !out_valid_reg || result.ready;

    // record arithmetic
    assign is_err   = (item.resp_status < 10'd200) || (item.resp_status >= 10'd300);
    assign byte_sum = {1'b0, bytes_reg} + (BYTE_W + 1)'(item.byte_count);

    // percentile arithmetic
    assign total_sum = total_reg + TOT_W'(rd_val);
    assign want      = SC_W'(total_reg) * SC_W'(pct_target(ti_reg));
    assign cum100    = SC_W'(cum_reg) * SC_W'(100);
    assign prev100   = SC_W'(prev_reg) * SC_W'(100);
    assign prod      = PROD_W'(num_reg) * PROD_W'(bucket_range(addr_reg));
    assign div_t     = {rem_reg, low_reg[RNG_W-1]};
    assign div_ge    = div_t >= {1'b0, den_reg};
    assign q_next    = {q_reg[RNG_W-2:0], div_ge};

    // control and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
            bytes_reg     <= '0;
            ti_reg        <= '0;
            addr_reg      <= '0;
            for (int i = 0; i < NCNT; i++)
                ctr_reg[i] <= '0;
        end
        else
        begin
            raddr_reg <= raddr;

            // result word valid: set on load, cleared when taken
            if (state_reg == S_OUT && out_free)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (acc && item.operation == OP_RECORD)
                    begin
                        ctr_reg[C_TOT] <= sat_inc(ctr_reg[C_TOT]);
                        if (item.is_second_protocol)
                            ctr_reg[C_V2] <= sat_inc(ctr_reg[C_V2]);
                        else
                            ctr_reg[C_V1] <= sat_inc(ctr_reg[C_V1]);
                        if (is_err)
                        begin
                            ctr_reg[C_ERR] <= sat_inc(ctr_reg[C_ERR]);
                            if (item.is_second_protocol)
                                ctr_reg[C_EV2] <= sat_inc(ctr_reg[C_EV2]);
                            else
                                ctr_reg[C_EV1] <= sat_inc(ctr_reg[C_EV1]);
                        end
                        bytes_reg <= byte_sum[BYTE_W] ? '1 : byte_sum[BYTE_W-1:0];
                        state_reg <= S_REC;
                    end
                    else if (acc)
                    begin
                        total_reg <= '0;
                        cum_reg   <= '0;
                        addr_reg  <= '0;
                        ti_reg    <= '0;
                        for (int k = 0; k < 3; k++)
                            pct_reg[k] <= '0;
                        state_reg <= S_SUM_RD;
                    end
                end

                // bucket write back
                S_REC:
                begin
                    valid_reg[raddr_reg] <= 1'b1;
                    state_reg            <= S_IDLE;
                end

                S_SUM_RD:
                    state_reg <= S_SUM_ACC;

                // histogram total
                S_SUM_ACC:
                begin
                    total_reg <= total_sum;
                    if (addr_reg == NBW'(NB - 1))
                    begin
                        addr_reg  <= '0;
                        state_reg <= (total_sum == '0) ? S_OUT : S_WALK_RD;
                    end
                    else
                    begin
                        addr_reg  <= addr_reg + NBW'(1);
                        state_reg <= S_SUM_RD;
                    end
                end

                S_WALK_RD:
                    state_reg <= S_WALK_CHK;

                // cumulative walk, skip empty buckets
                S_WALK_CHK:
                begin
                    if (rd_val != '0)
                    begin
                        prev_reg  <= cum_reg;
                        cum_reg   <= cum_reg + TOT_W'(rd_val);
                        cnt_reg   <= rd_val;
                        state_reg <= S_TGT;
                    end
                    else if (addr_reg == NBW'(NB - 1))
                    begin
                        for (int k = 0; k < 3; k++)
                            if (2'(k) >= ti_reg)
                                pct_reg[k] <= LAT_W'(LAST_SPAN);
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        addr_reg  <= addr_reg + NBW'(1);
                        state_reg <= S_WALK_RD;
                    end
                end

                // does the next target resolve in this bucket
                S_TGT:
                begin
                    if (ti_reg == 2'd3)
                        state_reg <= S_OUT;
                    else if (cum100 >= want)
                    begin
                        num_reg   <= (want > prev100) ? DEN_W'(want - prev100) : '0;
                        den_reg   <= DEN_W'(SC_W'(cnt_reg) * SC_W'(100));
                        state_reg <= S_MUL;
                    end
                    else if (addr_reg == NBW'(NB - 1))
                    begin
                        for (int k = 0; k < 3; k++)
                            if (2'(k) >= ti_reg)
                                pct_reg[k] <= LAT_W'(LAST_SPAN);
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        addr_reg  <= addr_reg + NBW'(1);
                        state_reg <= S_WALK_RD;
                    end
                end

                // scale by bucket range, split for the divider
                S_MUL:
                begin
                    rem_reg   <= prod[PROD_W-1:RNG_W];
                    low_reg   <= prod[RNG_W-1:0];
                    q_reg     <= '0;
                    step_reg  <= '0;
                    state_reg <= S_DIV;
                end

                // restoring division, one quotient bit a cycle
                S_DIV:
                begin
                    rem_reg  <= div_ge ? DEN_W'(div_t - {1'b0, den_reg}) : DEN_W'(div_t);
                    low_reg  <= {low_reg[RNG_W-2:0], 1'b0};
                    q_reg    <= q_next;
                    step_reg <= step_reg + 4'd1;
                    if (step_reg == 4'(RNG_W - 1))
                    begin
                        pct_reg[ti_reg] <= bucket_low(addr_reg) + q_next;
                        ti_reg          <= ti_reg + 2'd1;
                        state_reg       <= S_TGT;
                    end
                end

                // load result word and clear state
                S_OUT:
                begin
                    if (out_free)
                    begin
                        result.requests_total <= 32'(ctr_reg[C_TOT]);
                        result.requests_v1    <= 32'(ctr_reg[C_V1]);
                        result.requests_v2    <= 32'(ctr_reg[C_V2]);
                        result.errors_total   <= 32'(ctr_reg[C_ERR]);
                        result.errors_v1      <= 32'(ctr_reg[C_EV1]);
                        result.errors_v2      <= 32'(ctr_reg[C_EV2]);
                        result.bytes_total    <= bytes_reg;
                        result.median_latency <= pct_reg[0];
                        result.p90_latency    <= pct_reg[1];
                        result.p99_latency    <= pct_reg[2];
                        for (int i = 0; i < NCNT; i++)
                            ctr_reg[i] <= '0;
                        bytes_reg <= '0;
                        valid_reg <= '0;
                        state_reg <= S_IDLE;
                    end
                end

                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

    assign result.valid = out_valid_reg;

    // divider remainder stays below the divisor
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> rem_reg < den_reg)
        else $error("divider remainder out of range");

    // a division only runs for an open target
    a_div_ti: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> ti_reg != 2'd3)
        else $error("division with no open target");

    // result word appears only from the report state
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_OUT))
        else $error("result without flush");

    // flush leaves the histogram empty
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && out_free) |=> valid_reg == '0 && bytes_reg == '0)
        else $error("state not cleared after flush");

endmodule
`default_nettype wire

// ===== test/lhpm_tb_pkg.sv =====
// package: testbench word types for the latency histogram monitor
package lhpm_tb_pkg;
    import lhpm_pkg::*;

    typedef struct packed {
        logic        operation;
        logic [31:0] req_latency;
        logic [9:0]  resp_status;
        logic [31:0] byte_count;
        logic        is_second_protocol;
    } item_word_t;

    typedef struct packed {
        logic [31:0] requests_total;
        logic [31:0] requests_v1;
        logic [31:0] requests_v2;
        logic [31:0] errors_total;
        logic [31:0] errors_v1;
        logic [31:0] errors_v2;
        logic [47:0] bytes_total;
        logic [14:0] median_latency;
        logic [14:0] p90_latency;
        logic [14:0] p99_latency;
    } report_word_t;
endpackage

// ===== test/tb_top.sv =====
// testbench top: drives records and flushes, checks each report against a predictor
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import lhpm_pkg::*;
    import lhpm_tb_pkg::*;

    localparam int LIMIT_CYCLES = 2000000;
    localparam int DRAIN_CYCLES = 400;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    lhpm_item_if   item ();
    lhpm_result_if result ();

    latency_histogram_percentile_monitor_core DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item.sink),
        .result (result.source)
    );

    always #5 clk = ~clk;

    // predictor state
    logic [31:0]  req_cnt [NCNT];
    logic [47:0]  byte_acc;
    logic [31:0]  hist [NB];
    report_word_t pending_reports [$];

    int errors = 0;
    int reports_seen = 0;
    int records_sent = 0;
    int flushes_sent = 0;
    longint cycle = 0;
    bit  rx_stall_mode = 0;
    bit  tx_no_gaps = 0;

    function automatic logic [31:0] bump(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    function automatic longint unsigned low_bound(input int i);
        longint unsigned lows [NB] = '{0, 64, 128, 256, 512, 1000, 2000, 4000, 8000, 16000};
        return lows[i];
    endfunction

    function automatic void clear_histogram();
        for (int i = 0; i < NCNT; i++) req_cnt[i] = '0;
        for (int i = 0; i < NB; i++) hist[i] = '0;
        byte_acc = '0;
    endfunction

    // update counters and buckets for one request word
    function automatic void record_request(input item_word_t w);
        int b;
        longint unsigned sum;
        b = NB - 1;
        req_cnt[C_TOT] = bump(req_cnt[C_TOT]);
        if (w.is_second_protocol) req_cnt[C_V2] = bump(req_cnt[C_V2]);
        else req_cnt[C_V1] = bump(req_cnt[C_V1]);
        if (w.resp_status < 200 || w.resp_status >= 300)
        begin
            req_cnt[C_ERR] = bump(req_cnt[C_ERR]);
            if (w.is_second_protocol) req_cnt[C_EV2] = bump(req_cnt[C_EV2]);
            else req_cnt[C_EV1] = bump(req_cnt[C_EV1]);
        end
        sum = longint'(byte_acc) + longint'(w.byte_count);
        byte_acc = (sum > 64'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : sum[47:0];
        for (int i = NB - 2; i >= 0; i--)
            if (longint'(w.req_latency) < low_bound(i + 1)) b = i;
        hist[b] = bump(hist[b]);
    endfunction

    // interpolated p50/p90/p99 from the histogram, exact integers
    function automatic report_word_t build_report();
        report_word_t r;
        longint unsigned total, cum, prev, cnt, span, want, num, pct [3], tgt [3];
        int ti;
        tgt = '{50, 90, 99};
        pct = '{0, 0, 0};
        total = 0;
        cum = 0;
        ti = 0;
        for (int i = 0; i < NB; i++) total += hist[i];
        if (total != 0)
        begin
            for (int i = 0; i < NB; i++)
            begin
                cnt = hist[i];
                if (cnt != 0 && ti < 3)
                begin
                    prev = cum;
                    cum += cnt;
                    span = (i == NB - 1) ? 16000 : low_bound(i + 1) - low_bound(i);
                    while (ti < 3 && 100 * cum >= tgt[ti] * total)
                    begin
                        want = tgt[ti] * total;
                        num = (want > 100 * prev) ? want - 100 * prev : 0;
                        pct[ti] = low_bound(i) + (num * span) / (100 * cnt);
                        ti++;
                    end
                end
            end
            for (; ti < 3; ti++) pct[ti] = 16000;
        end
        r.requests_total = req_cnt[C_TOT];
        r.requests_v1    = req_cnt[C_V1];
        r.requests_v2    = req_cnt[C_V2];
        r.errors_total   = req_cnt[C_ERR];
        r.errors_v1      = req_cnt[C_EV1];
        r.errors_v2      = req_cnt[C_EV2];
        r.bytes_total    = byte_acc;
        r.median_latency = pct[0][14:0];
        r.p90_latency    = pct[1][14:0];
        r.p99_latency    = pct[2][14:0];
        return r;
    endfunction

    // sender: one word, with bursty gaps; valid stays up for a following word
    task automatic send_word(input item_word_t w);
        if (!tx_no_gaps && $urandom_range(0, 5) == 0)
        begin
            item.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        item.valid              <= 1'b1;
        item.operation          <= w.operation;
        item.req_latency        <= w.req_latency;
        item.resp_status        <= w.resp_status;
        item.byte_count         <= w.byte_count;
        item.is_second_protocol <= w.is_second_protocol;
        do @(posedge clk); while (!item.ready);
        if (w.operation == OP_FLUSH)
        begin
            pending_reports.push_back(build_report());
            clear_histogram();
            flushes_sent++;
        end
        else
        begin
            record_request(w);
            records_sent++;
        end
    endtask

    function automatic item_word_t make_record(input logic [31:0] lat,
                                               input logic [9:0] st,
                                               input logic [31:0] nbytes,
                                               input logic v2);
        item_word_t w;
        w.operation = OP_RECORD;
        w.req_latency = lat;
        w.resp_status = st;
        w.byte_count = nbytes;
        w.is_second_protocol = v2;
        return w;
    endfunction

    function automatic item_word_t make_flush();
        item_word_t w;
        w = item_word_t'({$urandom, $urandom, $urandom});
        w.operation = OP_FLUSH;
        return w;
    endfunction

    // latency biased toward bucket edges
    function automatic logic [31:0] pick_latency();
        int k;
        k = $urandom_range(0, 9);
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'(low_bound(k)) - 32'($urandom_range(0, 1));
            default: return 32'($urandom_range(0, 20000));
        endcase
    endfunction

    function automatic logic [9:0] pick_status();
        case ($urandom_range(0, 3))
            0: return 10'($urandom);
            1: return 10'($urandom_range(199, 300));
            default: return 10'($urandom_range(200, 299));
        endcase
    endfunction

    function automatic item_word_t random_record();
        return make_record(pick_latency(), pick_status(),
                           ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 4096),
                           1'($urandom_range(0, 1)));
    endfunction

    // directed: empty flush, field extremes, every bucket edge
    task automatic test_directed();
        send_word(make_flush());
        send_word(make_record(32'd0, 10'd0, 32'd0, 1'b0));
        send_word(make_record(32'hFFFF_FFFF, 10'h3FF, 32'hFFFF_FFFF, 1'b1));
        send_word(make_record(32'd63, 10'd200, 32'd1, 1'b0));
        send_word(make_record(32'd64, 10'd299, 32'd2, 1'b1));
        send_word(make_record(32'd199, 10'd199, 32'hAAAA_AAAA, 1'b0));
        send_word(make_record(32'd15999, 10'd300, 32'h5555_5555, 1'b1));
        send_word(make_record(32'd16000, 10'd250, 32'd7, 1'b0));
        send_word(make_flush());
        for (int i = 1; i < NB; i++)
            send_word(make_record(32'(low_bound(i)) - 32'd1, 10'(i * 100), 32'(i), i[0]));
        send_word(make_flush());
        // single request in the top bucket
        send_word(make_record(32'h5555_5555, 10'h2AA, 32'h0, 1'b1));
        send_word(make_flush());
    endtask

    // large byte counts, accumulator carries well past 32 bits
    task automatic test_byte_accumulation();
        for (int i = 0; i < 200; i++)
        begin
            tx_no_gaps = (i > 20);
            send_word(make_record(32'(i % 300), 10'd200, 32'hFFFF_FFFF, i[0]));
        end
        tx_no_gaps = 0;
        send_word(make_flush());
    endtask

    // random sessions of records ended by a flush
    task automatic test_random_sessions(input int budget);
        int sent;
        int len;
        sent = 0;
        while (sent < budget)
        begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : $urandom_range(5, 80);
            tx_no_gaps = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < len; i++)
                send_word(random_record());
            send_word(make_flush());
            sent += len + 1;
        end
        tx_no_gaps = 0;
    endtask

    // receiver stall pattern, alternating phases
    always @(posedge clk)
    begin
        if (!rst_n)
            result.ready <= 1'b0;
        else if (rx_stall_mode)
            result.ready <= ($urandom_range(0, 3) == 0);
        else
            result.ready <= (cycle % 64 < 40) || (cycle[2:0] == 3'd5);
        if (cycle % 500 == 0) rx_stall_mode <= $urandom_range(0, 1);
    end

    // result checker
    always @(posedge clk)
    begin
        report_word_t got, want;
        cycle <= cycle + 1;
        if (rst_n && result.valid && result.ready)
        begin
            got = '{result.requests_total, result.requests_v1, result.requests_v2,
                    result.errors_total, result.errors_v1, result.errors_v2,
                    result.bytes_total, result.median_latency, result.p90_latency,
                    result.p99_latency};
            reports_seen++;
            if (pending_reports.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected report word %p", got);
            end
            else
            begin
                want = pending_reports.pop_front();
                if (got !== want)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("report mismatch\n  expected %p\n  actual   %p", want, got);
                end
            end
        end
    end

    // run watchdog
    always @(posedge clk)
    begin
        if (cycle > LIMIT_CYCLES)
        begin
            $display("timeout at cycle %0d", cycle);
            $display("tb_top NOT OK");
            $finish;
        end
    end

    initial
    begin
        item.valid = 1'b0;
        item.operation = OP_RECORD;
        item.req_latency = '0;
        item.resp_status = '0;
        item.byte_count = '0;
        item.is_second_protocol = 1'b0;
        result.ready = 1'b0;
        clear_histogram();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_byte_accumulation();
        test_random_sessions(1530);
        item.valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d records and %0d flushes, %0d reports checked",
                 records_sent, flushes_sent, reports_seen);
        $display("bucket edges, error codes, wide byte sums and empty reports exercised");
        if (errors == 0 && pending_reports.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/lhpm_pkg.sv
rtl/lhpm_item_if.sv
rtl/lhpm_result_if.sv
rtl/lhpm_ram.sv
rtl/latency_histogram_percentile_monitor_core.sv
test/lhpm_tb_pkg.sv
test/tb_top.sv
